@@ src/assert_macros.svh @@
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/igmp_pkg.sv @@
`default_nettype none

package igmp_pkg;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_MSG_HDR = 3'd0,
        PH_REC_HDR = 3'd1,
        PH_SOURCE  = 3'd2,
        PH_AUX     = 3'd3,
        PH_DONE    = 3'd4,
        PH_ERROR   = 3'd5
    } t_phase;

    // Result kinds.
    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_SOURCE = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // End-of-message status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SHORT   = 2'd1;
    localparam logic [1:0] ST_BADTYPE = 2'd2;

    // Header layout.
    localparam logic [2:0] HDR_LAST_POS   = 3'd7;
    localparam logic [2:0] HDR_COUNT_HI   = 3'd6;
    localparam logic [2:0] REC_TYPE_POS   = 3'd0;
    localparam logic [2:0] REC_AUX_POS    = 3'd1;
    localparam logic [2:0] REC_SRC_HI_POS = 3'd2;
    localparam logic [2:0] REC_SRC_LO_POS = 3'd3;
    localparam logic [2:0] ADDR_LAST_POS  = 3'd3;
    localparam logic [7:0] TYPE_MIN       = 8'd1;
    localparam logic [7:0] TYPE_MAX       = 8'd6;

    // One result transaction.
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  rec_type;
        logic [31:0] grp_addr;
        logic [15:0] source_count;
        logic [31:0] src_addr;
        logic [1:0]  status;
        logic        final_of_run;
    } t_result;

    // Phase that follows a completed header, address or auxiliary block.
    function automatic t_phase next_section(input logic [15:0] sources_left,
                                            input logic [9:0]  aux_left,
                                            input logic [15:0] records_left);
        t_phase ph;
        if (sources_left != 16'd0) begin
            ph = PH_SOURCE;
        end else if (aux_left != 10'd0) begin
            ph = PH_AUX;
        end else if (records_left != 16'd0) begin
            ph = PH_REC_HDR;
        end else begin
            ph = PH_DONE;
        end
        return ph;
    endfunction

endpackage

`default_nettype wire

@@ src/igmp_parse_core.sv @@
`default_nettype none

module igmp_parse_core
    import igmp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_end_of_message,
    output t_result         o_res_a,
    output t_result         o_res_b,
    output logic [1:0]      o_res_cnt
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    logic [15:0] r_records, n_records;
    logic [15:0] r_sources, n_sources;
    logic [9:0]  r_aux, n_aux;
    logic [31:0] r_word, n_word;
    logic [2:0]  r_type, n_type;
    logic [1:0]  r_err, n_err;

    logic        emit_rec;
    logic        emit_src;
    logic [1:0]  end_status;

    // Next state for one byte; the end mark returns everything to reset values.
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_records = r_records;
        n_sources = r_sources;
        n_aux     = r_aux;
        n_word    = r_word;
        n_type    = r_type;
        n_err     = r_err;
        emit_rec  = 1'b0;
        emit_src  = 1'b0;

        case (r_phase)
            PH_MSG_HDR: begin
                if (r_pos == HDR_COUNT_HI) begin
                    n_records = {i_data_byte, 8'h00};
                end
                if (r_pos == HDR_LAST_POS) begin
                    n_records = {r_records[15:8], i_data_byte};
                    n_pos     = 3'd0;
                    n_phase   = (n_records != 16'd0) ? PH_REC_HDR : PH_DONE;
                end else begin
                    n_pos = r_pos + 3'd1;
                end
            end
            PH_REC_HDR: begin
                case (r_pos)
                    REC_TYPE_POS: begin
                        n_type = (i_data_byte inside {[TYPE_MIN:TYPE_MAX]})
                                 ? i_data_byte[2:0] : 3'd0;
                    end
                    REC_AUX_POS:    n_aux     = {i_data_byte, 2'b00};
                    REC_SRC_HI_POS: n_sources = {i_data_byte, 8'h00};
                    REC_SRC_LO_POS: n_sources = {r_sources[15:8], i_data_byte};
                    default:        n_word    = {r_word[23:0], i_data_byte};
                endcase
                if (r_pos == HDR_LAST_POS) begin
                    n_pos = 3'd0;
                    if (r_type == 3'd0) begin
                        n_err   = ST_BADTYPE;
                        n_phase = PH_ERROR;
                    end else begin
                        emit_rec  = 1'b1;
                        n_records = r_records - 16'd1;
                        n_phase   = next_section(r_sources, r_aux, n_records);
                    end
                end else begin
                    n_pos = r_pos + 3'd1;
                end
            end
            PH_SOURCE: begin
                n_word = {r_word[23:0], i_data_byte};
                if (r_pos >= ADDR_LAST_POS) begin
                    emit_src  = 1'b1;
                    n_sources = r_sources - 16'd1;
                    n_pos     = 3'd0;
                    n_phase   = next_section(n_sources, r_aux, r_records);
                end else begin
                    n_pos = r_pos + 3'd1;
                end
            end
            PH_AUX: begin
                n_aux = r_aux - 10'd1;
                if (n_aux == 10'd0) begin
                    n_pos   = 3'd0;
                    n_phase = next_section(r_sources, n_aux, r_records);
                end
            end
            default: begin
            end
        endcase

        // Status is taken from the state this byte leaves behind.
        if (n_err != ST_OK) begin
            end_status = n_err;
        end else begin
            end_status = (n_phase == PH_DONE) ? ST_OK : ST_SHORT;
        end

        if (i_end_of_message) begin
            n_phase   = PH_MSG_HDR;
            n_pos     = 3'd0;
            n_records = 16'd0;
            n_sources = 16'd0;
            n_aux     = 10'd0;
            n_word    = 32'd0;
            n_type    = 3'd0;
            n_err     = ST_OK;
        end
    end

    // Results caused by this byte: a record or source first, then the status.
    always_comb begin
        t_result item;
        t_result stat;

        item              = '0;
        item.kind         = emit_src ? KIND_SOURCE : KIND_RECORD;
        item.rec_type     = emit_rec ? r_type : 3'd0;
        item.grp_addr     = emit_rec ? {r_word[23:0], i_data_byte} : 32'd0;
        item.source_count = emit_rec ? r_sources : 16'd0;
        item.src_addr     = emit_src ? {r_word[23:0], i_data_byte} : 32'd0;
        item.final_of_run = !i_end_of_message;

        stat              = '0;
        stat.kind         = KIND_STATUS;
        stat.status       = end_status;
        stat.final_of_run = 1'b1;

        o_res_a   = (emit_rec || emit_src) ? item : stat;
        o_res_b   = stat;
        o_res_cnt = {1'b0, (emit_rec || emit_src)} + {1'b0, i_end_of_message};
    end

    // State registers, updated on each accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_MSG_HDR;
            r_pos     <= 3'd0;
            r_records <= 16'd0;
            r_sources <= 16'd0;
            r_aux     <= 10'd0;
            r_word    <= 32'd0;
            r_type    <= 3'd0;
            r_err     <= ST_OK;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_records <= n_records;
            r_sources <= n_sources;
            r_aux     <= n_aux;
            r_word    <= n_word;
            r_type    <= n_type;
            r_err     <= n_err;
        end
    end

endmodule

`default_nettype wire

@@ src/igmp_out_queue.sv @@
`default_nettype none

module igmp_out_queue
    import igmp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_result    i_res_a,
    input  wire t_result    i_res_b,
    input  wire logic [1:0] i_res_cnt,
    input  wire logic       i_pop_ready,
    output logic            o_can_push,
    output logic            o_valid,
    output t_result         o_head
);

    t_result    r_slot0, n_slot0;
    t_result    r_slot1, n_slot1;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign pop        = (r_cnt != 2'd0) && i_pop_ready;
    // Push only when the queue is empty after this cycle's pop; not checked here.
    assign o_can_push = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_pop_ready);
    assign o_valid    = (r_cnt != 2'd0);
    assign o_head     = r_slot0;

    // Fill from empty on a push, otherwise shift down on a pop.
    always_comb begin
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        n_cnt   = r_cnt;
        if (i_push) begin
            n_slot0 = i_res_a;
            n_slot1 = i_res_b;
            n_cnt   = i_res_cnt;
        end else if (pop) begin
            n_slot0 = r_slot1;
            n_cnt   = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

endmodule

`default_nettype wire

@@ src/igmpv3_report_parser.sv @@
// A result is offered on the outputs the cycle after its byte is accepted.
// One byte is taken per cycle while results drain; an end-marked byte that also
// completes a record header or source address yields two results, and the two-entry
// result queue then holds the input while the first drains.
// Reset (i_rst_n low at a clock edge) returns the parser to the message header and
// empties the result queue.
`default_nettype none
`include "assert_macros.svh"

module igmpv3_report_parser
    import igmp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_message,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_kind,
    output logic [2:0]       o_rec_type,
    output logic [31:0]      o_grp_addr,
    output logic [15:0]      o_source_count,
    output logic [31:0]      o_src_addr,
    output logic [1:0]       o_status,
    output logic             o_final_of_run
);

    t_result    res_a;
    t_result    res_b;
    logic [1:0] res_cnt;
    logic       take;
    t_result    head;

    assign take = i_valid && o_ready;

    // Byte parser and its state.
    igmp_parse_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_take           (take),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_res_a          (res_a),
        .o_res_b          (res_b),
        .o_res_cnt        (res_cnt)
    );

    // Result register pair feeding the output channel.
    igmp_out_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (take),
        .i_res_a     (res_a),
        .i_res_b     (res_b),
        .i_res_cnt   (res_cnt),
        .i_pop_ready (i_ready),
        .o_can_push  (o_ready),
        .o_valid     (o_valid),
        .o_head      (head)
    );

    assign o_kind         = head.kind;
    assign o_rec_type     = head.rec_type;
    assign o_grp_addr     = head.grp_addr;
    assign o_source_count = head.source_count;
    assign o_src_addr     = head.src_addr;
    assign o_status       = head.status;
    assign o_final_of_run = head.final_of_run;

    // A status transaction always closes the run of its byte.
    `ASSERT_IMPLIES(a_status_final, i_clk, i_rst_n,
        o_valid && (o_kind == KIND_STATUS), o_final_of_run)
    // Input is taken only when the pending results can drain this cycle.
    `ASSERT_IMPLIES(a_ready_drains, i_clk, i_rst_n,
        o_ready && o_valid, i_ready)
    // Only status transactions carry a nonzero status.
    `ASSERT_IMPLIES(a_status_only_end, i_clk, i_rst_n,
        o_valid && (o_kind != KIND_STATUS), o_status == ST_OK)

endmodule

`default_nettype wire
